/* hw/rtl/ddd_pkg.sv */
// Shared widths, constants, calendar tables and controller commands for the date difference block.
package ddd_pkg;

  // Field widths.
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 22;

  // Shifted year p = y + 399 needs 15 bits; a day number needs 23 bits.
  localparam int PY_W   = 15;
  localparam int QUOT_W = 8;
  localparam int DN_W   = 23;
  localparam int DBM_W  = 9;

  localparam logic [PY_W-1:0] YEAR_SHIFT_M1 = 15'd399;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43690.
  localparam logic [PY_W-1:0] RECIP_100   = 15'd20972;
  localparam int              RECIP_SHIFT = 21;
  localparam logic [PY_W-1:0] HUNDRED     = 15'd100;
  localparam logic [PY_W-1:0] DAYS_PER_YR = 15'd365;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Month codes that bound the valid range, and February for the leap day.
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  typedef logic [DAY_W-1:0]  day_t;
  typedef logic [MON_W-1:0]  month_t;
  typedef logic [YEAR_W-1:0] year_t;
  typedef logic [CNT_W-1:0]  count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transaction
    logic sel;     // 0 works on the start date, 1 on the end date
    logic quot_y;  // year / 100
    logic quot_p;  // shifted year / 100, leap and validity check
    logic scale;   // 365 * shifted year
    logic sum;     // finish the day number
    logic emit;    // load the result register
  } ddd_cmd_t;

  // Length of a month; codes outside 1..12 give 0.
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of a month.
  function automatic logic [DBM_W-1:0] days_before(input month_t m);
    logic [DBM_W-1:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/ddd_ifs.sv */
// Valid/ready channel interfaces for the date pair input and the day count result.
interface ddd_in_if;
  import ddd_pkg::*;

  logic   valid;
  logic   ready;
  day_t   start_day;
  month_t start_month;
  year_t  start_year;
  day_t   end_day;
  month_t end_month;
  year_t  end_year;
  logic   count_end_day;

  modport source (
    output valid, start_day, start_month, start_year,
    output end_day, end_month, end_year, count_end_day,
    input  ready
  );
  modport sink (
    input  valid, start_day, start_month, start_year,
    input  end_day, end_month, end_year, count_end_day,
    output ready
  );
endinterface

interface ddd_out_if;
  import ddd_pkg::*;

  logic   valid;
  logic   ready;
  count_t day_count;
  logic   bad_date;

  modport source (output valid, day_count, bad_date, input ready);
  modport sink (input valid, day_count, bad_date, output ready);
endinterface

/* hw/rtl/ddd_ctrl.sv */
// Controller state machine that sequences the day number computation for both dates.
module ddd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ddd_pkg::ddd_cmd_t cmd
);
  import ddd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_QUOTY = 6'b000010,
    ST_QUOTP = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_SUM   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit;

  // The result register may be loaded when it is empty or being drained.
  assign emit      = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and date select.
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_QUOTY;
          sel_nxt   = 1'b0;
        end
      end
      ST_QUOTY: state_nxt = ST_QUOTP;
      ST_QUOTP: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_SUM;
      ST_SUM: begin
        if (sel_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_QUOTY;
          sel_nxt   = 1'b1;
        end
      end
      ST_DONE: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.sel    = sel_r;
    cmd.quot_y = (state_r == ST_QUOTY);
    cmd.quot_p = (state_r == ST_QUOTP);
    cmd.scale  = (state_r == ST_SCALE);
    cmd.sum    = (state_r == ST_SUM);
    cmd.emit   = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/ddd_datapath.sv */
// Datapath: input capture, shared reciprocal multiplier, day number accumulation and result register.
module ddd_datapath (
  input  logic              clk,
  input  ddd_pkg::ddd_cmd_t cmd,
  input  ddd_pkg::day_t     in_start_day,
  input  ddd_pkg::month_t   in_start_month,
  input  ddd_pkg::year_t    in_start_year,
  input  ddd_pkg::day_t     in_end_day,
  input  ddd_pkg::month_t   in_end_month,
  input  ddd_pkg::year_t    in_end_year,
  input  logic              in_count_end_day,
  output ddd_pkg::count_t   out_day_count,
  output logic              out_bad_date
);
  import ddd_pkg::*;

  // Captured transaction.
  day_t   sd_r, ed_r;
  month_t sm_r, em_r;
  year_t  sy_r, ey_r;
  logic   inc_r;

  // Per-date working registers.
  logic [QUOT_W-1:0] qy_r, qp_r;
  logic              leap_r;
  logic [DN_W-1:0]   base_r;
  logic [DN_W-1:0]   a_r, b_r;
  logic              ok_s_r, ok_e_r;

  // Result register.
  count_t cnt_r;
  logic   bad_r;

  day_t              d;
  month_t            m;
  year_t             y;
  logic [PY_W-1:0]   p;
  logic [PY_W-1:0]   mul_in;
  logic [2*PY_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [PY_W-1:0]   qy_x100;
  logic              hund;
  logic              leap_c;
  logic              ok_c;
  logic [DN_W-1:0]   dn_c;
  logic [DN_W-1:0]   diff;
  logic [DN_W-1:0]   total;
  count_t            cnt_c;

  // Pick the date being worked on.
  assign d = cmd.sel ? ed_r : sd_r;
  assign m = cmd.sel ? em_r : sm_r;
  assign y = cmd.sel ? ey_r : sy_r;
  assign p = PY_W'(y) + YEAR_SHIFT_M1;

  // Shared divide-by-100 through a reciprocal multiply.
  assign mul_in = cmd.quot_y ? PY_W'(y) : p;
  assign prod   = (2*PY_W)'(mul_in) * (2*PY_W)'(RECIP_100);
  assign quot   = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];

  // Leap year from year / 100: divisible by 100 means the century test applies.
  assign qy_x100 = PY_W'(qy_r) * HUNDRED;
  assign hund    = (PY_W'(y) == qy_x100);
  assign leap_c  = ((y[1:0] == 2'b00) && !hund) || (hund && (qy_r[1:0] == 2'b00));

  // Date validity.
  assign ok_c = (m >= MON_JAN) && (m <= MON_DEC) && (d != '0) && (d <= month_len(m, leap_c));

  // Remaining terms of the day number.
  assign dn_c = base_r
              + DN_W'(p >> 2)
              - DN_W'(qp_r)
              + DN_W'(qp_r >> 2)
              + DN_W'(days_before(m))
              + DN_W'(leap_r && (m > MON_FEB))
              + DN_W'(d);

  // Difference, end-day flag and saturation.
  assign diff  = (a_r < b_r) ? (b_r - a_r) : '0;
  assign total = diff + DN_W'(inc_r);
  assign cnt_c = (total > DN_W'(COUNT_MAX)) ? COUNT_MAX : total[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sd_r  <= in_start_day;
      sm_r  <= in_start_month;
      sy_r  <= in_start_year;
      ed_r  <= in_end_day;
      em_r  <= in_end_month;
      ey_r  <= in_end_year;
      inc_r <= in_count_end_day;
    end
    if (cmd.quot_y) begin
      qy_r <= quot;
    end
    if (cmd.quot_p) begin
      qp_r   <= quot;
      leap_r <= leap_c;
      if (cmd.sel) begin
        ok_e_r <= ok_c;
      end else begin
        ok_s_r <= ok_c;
      end
    end
    if (cmd.scale) begin
      base_r <= DN_W'(p) * DN_W'(DAYS_PER_YR);
    end
    if (cmd.sum) begin
      if (cmd.sel) begin
        b_r <= dn_c;
      end else begin
        a_r <= dn_c;
      end
    end
    if (cmd.emit) begin
      bad_r <= !(ok_s_r && ok_e_r);
      cnt_r <= (ok_s_r && ok_e_r) ? cnt_c : '0;
    end
  end

  assign out_day_count = cnt_r;
  assign out_bad_date  = bad_r;

endmodule

/* hw/rtl/date_difference_in_days.sv */
// The block takes one transaction at a time; a new one is accepted only in the idle state.
// Each date takes four steps: year/100 and
// shifted year/100 on one shared reciprocal multiplier, 365 * shifted year, final sum.
// The result register is then loaded in the done state, which waits while a previous result stalls.
// A finished result waits in an output register while the next transaction is taken.
// Reset: synchronous, active-low rst_n; clears the controller and the result valid flag.
// Top level: Gregorian date difference in days with invalid-date detection.
module date_difference_in_days (
  input  logic   clk,
  input  logic   rst_n,
  ddd_in_if.sink   in_ch,
  ddd_out_if.source out_ch
);
  import ddd_pkg::*;

  ddd_cmd_t cmd;

  // Sequencer.
  ddd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Arithmetic and result storage.
  ddd_datapath u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .in_start_day     (in_ch.start_day),
    .in_start_month   (in_ch.start_month),
    .in_start_year    (in_ch.start_year),
    .in_end_day       (in_ch.end_day),
    .in_end_month     (in_ch.end_month),
    .in_end_year      (in_ch.end_year),
    .in_count_end_day (in_ch.count_end_day),
    .out_day_count    (out_ch.day_count),
    .out_bad_date     (out_ch.bad_date)
  );

endmodule

/* hw/rtl/ddd_checker.sv */
// Port-level checker for the date difference block and its bind to the top level.
module ddd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ddd_pkg::count_t day_count,
  input logic            bad_date
);
  import ddd_pkg::*;

  // An invalid date always reports a zero count.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_date |-> day_count == '0)
    else $error("bad_date result with nonzero day_count");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a transaction");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(day_count) && $stable(bad_date))
    else $error("result payload changed while stalled");

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .day_count (out_ch.day_count),
  .bad_date  (out_ch.bad_date)
);

/* tb/ddd_day_count_checker.sv */
// Checker that predicts each day count from accepted date pairs and compares the results.
module ddd_day_count_checker (
  input  logic        clk,
  input  logic        rst_n,
  ddd_in_if           in_ch,
  ddd_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned invalid_seen,
  output int unsigned saturated_seen
);
  import ddd_pkg::*;

  typedef struct packed {
    count_t day_count;
    logic   bad_date;
  } day_result_t;

  // Month lengths in a common year, indexed by month number.
  localparam int unsigned MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  day_result_t expected_counts [$];
  int unsigned errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_invalid = 0;
  int unsigned n_saturated = 0;

  function automatic logic is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic date_valid(input day_t d, input month_t m, input year_t y);
    int unsigned len;
    if (m < MON_JAN || m > MON_DEC || d == 0) return 1'b0;
    len = MONTH_DAYS[m];
    if (m == MON_FEB && is_leap(y)) len = 29;
    return d <= len;
  endfunction

  // Days since a fixed origin; the year is pushed up by 399 so year 0 stays positive.
  function automatic int unsigned day_index(input day_t d, input month_t m, input year_t y);
    int unsigned p;
    int unsigned n;
    p = int'(y) + 399;
    n = 365 * p + p / 4 - p / 100 + p / 400 + d;
    for (int i = 1; i < m; i++) n += MONTH_DAYS[i];
    if (m > MON_FEB && is_leap(y)) n += 1;
    return n;
  endfunction

  function automatic day_result_t predict_span(
    input day_t sd, input month_t sm, input year_t sy,
    input day_t ed, input month_t em, input year_t ey,
    input logic inc
  );
    day_result_t r;
    int unsigned a;
    int unsigned b;
    int unsigned n;
    r.bad_date  = !date_valid(sd, sm, sy) || !date_valid(ed, em, ey);
    r.day_count = '0;
    if (!r.bad_date) begin
      a = day_index(sd, sm, sy);
      b = day_index(ed, em, ey);
      n = (a < b) ? b - a : 0;
      n += inc;
      r.day_count = (n > COUNT_MAX) ? COUNT_MAX : count_t'(n);
    end
    return r;
  endfunction

  // Results are retired before new date pairs are queued, so a result can never
  // match a transaction taken on the same edge.
  always @(posedge clk) begin
    day_result_t exp_r;
    day_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.day_count = out_ch.day_count;
        got.bad_date  = out_ch.bad_date;
        if (expected_counts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: day count %0d bad_date %0b arrived with no date pair pending",
                     got.day_count, got.bad_date);
        end else begin
          exp_r = expected_counts.pop_front();
          n_checked++;
          if (got.day_count !== exp_r.day_count || got.bad_date !== exp_r.bad_date) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result %0d: expected count %0d bad %0b, got count %0d bad %0b",
                       n_checked, exp_r.day_count, exp_r.bad_date,
                       got.day_count, got.bad_date);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        exp_r = predict_span(in_ch.start_day, in_ch.start_month, in_ch.start_year,
                             in_ch.end_day, in_ch.end_month, in_ch.end_year,
                             in_ch.count_end_day);
        if (exp_r.bad_date) n_invalid++;
        if (exp_r.day_count == COUNT_MAX) n_saturated++;
        expected_counts.push_back(exp_r);
      end
    end
    fail_count     <= errors;
    pending        <= expected_counts.size();
    checked        <= n_checked;
    invalid_seen   <= n_invalid;
    saturated_seen <= n_saturated;
  end

endmodule

/* tb/date_difference_in_days_tb.sv */
// Testbench top: drives date pairs with random idling and reports the checker's verdict.
module date_difference_in_days_tb;
  import ddd_pkg::*;

  localparam int unsigned RANDOM_PAIRS = 450;
  localparam int unsigned CALM_PAIRS   = 60;
  localparam int unsigned QUIET_LIMIT  = 1000;

  typedef struct {
    day_t   sd;
    month_t sm;
    year_t  sy;
    day_t   ed;
    month_t em;
    year_t  ey;
    logic   inc;
  } date_pair_t;

  logic clk;
  logic rst_n;
  logic calm;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned invalid_seen;
  int unsigned saturated_seen;
  int unsigned quiet_cycles = 0;

  ddd_in_if  in_ch ();
  ddd_out_if out_ch ();

  date_difference_in_days u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ddd_day_count_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .invalid_seen   (invalid_seen),
    .saturated_seen (saturated_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic date_pair_t date_pair(
    input int unsigned sd, input int unsigned sm, input int unsigned sy,
    input int unsigned ed, input int unsigned em, input int unsigned ey,
    input logic inc
  );
    date_pair_t p;
    p.sd = day_t'(sd);
    p.sm = month_t'(sm);
    p.sy = year_t'(sy);
    p.ed = day_t'(ed);
    p.em = month_t'(em);
    p.ey = year_t'(ey);
    p.inc = inc;
    return p;
  endfunction

  // Mostly well-formed, ordered date pairs; the rest is raw noise or month-end days
  // that may not exist in that month.
  function automatic date_pair_t random_pair();
    date_pair_t p;
    date_pair_t q;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    p.inc = 1'($urandom_range(0, 1));
    if (kind < 15) begin
      p.sd = day_t'($urandom);
      p.sm = month_t'($urandom);
      p.sy = year_t'($urandom);
      p.ed = day_t'($urandom);
      p.em = month_t'($urandom);
      p.ey = year_t'($urandom);
    end else begin
      p.sd = day_t'($urandom_range(1, 28));
      p.ed = day_t'($urandom_range(1, 28));
      p.sm = month_t'($urandom_range(1, 12));
      p.em = month_t'($urandom_range(1, 12));
      case ($urandom_range(0, 3))
        0: begin
          p.sy = year_t'($urandom_range(1, 9999));
          p.ey = year_t'($urandom_range(1, 9999));
        end
        1: begin
          p.sy = year_t'($urandom_range(1, 9999));
          p.ey = p.sy + year_t'($urandom_range(0, 2));
        end
        2: begin
          p.sy = year_t'($urandom_range(0, 16383));
          p.ey = year_t'($urandom_range(0, 16383));
        end
        default: begin
          // Century years exercise the 100 and 400 leap rules.
          p.sy = year_t'(100 * $urandom_range(0, 163));
          p.ey = p.sy + year_t'($urandom_range(0, 4));
        end
      endcase
      if (kind < 35) begin
        p.sd = day_t'($urandom_range(28, 31));
        p.ed = day_t'($urandom_range(28, 31));
      end
      if ({p.sy, p.sm, p.sd} > {p.ey, p.em, p.ed} && $urandom_range(0, 99) < 85) begin
        q = p;
        p.sd = q.ed;
        p.sm = q.em;
        p.sy = q.ey;
        p.ed = q.sd;
        p.em = q.sm;
        p.ey = q.sy;
      end
    end
    return p;
  endfunction

  // Present one date pair, optionally after a short gap, and hold it until taken.
  task automatic send_pair(input date_pair_t p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.start_day     <= p.sd;
    in_ch.start_month   <= p.sm;
    in_ch.start_year    <= p.sy;
    in_ch.end_day       <= p.ed;
    in_ch.end_month     <= p.em;
    in_ch.end_year      <= p.ey;
    in_ch.count_end_day <= p.inc;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: ready drops in short random bursts except in the calm phase.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.start_day     <= '0;
    in_ch.start_month   <= '0;
    in_ch.start_year    <= '0;
    in_ch.end_day       <= '0;
    in_ch.end_month     <= '0;
    in_ch.end_year      <= '0;
    in_ch.count_end_day <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs: equal and reversed dates, full range, leap rules, invalid dates,
    // years outside 1..9999 and saturation.
    send_pair(date_pair(15, 6, 2020, 15, 6, 2020, 1'b0));
    send_pair(date_pair(15, 6, 2020, 15, 6, 2020, 1'b1));
    send_pair(date_pair(1, 1, 2021, 31, 12, 2020, 1'b1));
    send_pair(date_pair(1, 1, 1, 31, 12, 9999, 1'b1));
    send_pair(date_pair(1, 1, 1, 31, 12, 9999, 1'b0));
    send_pair(date_pair(29, 2, 2000, 1, 3, 2000, 1'b0));
    send_pair(date_pair(29, 2, 1900, 1, 3, 1900, 1'b0));
    send_pair(date_pair(28, 2, 2023, 29, 2, 2024, 1'b0));
    send_pair(date_pair(29, 2, 2023, 1, 3, 2023, 1'b1));
    send_pair(date_pair(0, 5, 2010, 1, 6, 2010, 1'b0));
    send_pair(date_pair(1, 1, 2010, 31, 4, 2010, 1'b1));
    send_pair(date_pair(31, 1, 2010, 31, 12, 2010, 1'b0));
    send_pair(date_pair(1, 0, 2010, 1, 1, 2011, 1'b0));
    send_pair(date_pair(1, 1, 2010, 1, 13, 2010, 1'b0));
    send_pair(date_pair(31, 15, 16383, 31, 15, 16383, 1'b1));
    send_pair(date_pair(29, 2, 0, 1, 3, 0, 1'b0));
    send_pair(date_pair(1, 1, 0, 31, 12, 16383, 1'b1));
    send_pair(date_pair(1, 1, 0, 31, 12, 16383, 1'b0));
    send_pair(date_pair(1, 1, 16383, 31, 12, 16383, 1'b0));
    send_pair(date_pair(31, 12, 1999, 1, 1, 2000, 1'b0));
    send_pair(date_pair(1, 3, 2100, 1, 3, 2104, 1'b1));
    send_pair(date_pair(30, 11, 1, 1, 12, 9999, 1'b0));
    drain_results();

    // Random pairs, with one more full drain midway and no idling at the end.
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 2) drain_results();
      if (i == RANDOM_PAIRS - CALM_PAIRS) calm = 1'b1;
      send_pair(random_pair());
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d day counts: %0d with an invalid date, %0d saturated.",
             checked, invalid_seen, saturated_seen);
    $display("Mismatches: %0d, results still owed: %0d.", fail_count, pending);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
